// ----- design/cle_pkg.sv -----
package cle_pkg;

	// Line buffer size; the line holds at most LINE_SIZE-1 characters.
	localparam int LINE_SIZE = 32;
	localparam int FILL_W    = $clog2(LINE_SIZE);

	// Result field widths and the packed output data word.
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int CNT_W   = 32;
	localparam int CHAR_W  = 7;
	localparam int FIELD_W = BYTE_W + LEN_W + CNT_W;
	localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - FIELD_W;

	// Character codes.
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_LOW   = 8'd32;
	localparam logic [BYTE_W-1:0] CH_HIGH  = 8'd126;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

endpackage

// ----- design/console_line_editor.sv -----
// Console line editor.
// The slave stream takes one received serial byte per request (tdata bits 7:0).
// The master stream returns the responses: echo bytes for the transmitter
// (tuser 0) and, after a carriage return on a nonempty line, the characters of
// the completed line in order (tuser 1). tlast marks the final response of one
// received byte. Bytes that cause no response (line feed, control codes, high
// bytes, a delete on an empty line, a printable byte on a full line) are simply
// consumed.
// A byte is taken in the idle state and decoded in the next cycle; its first echo
// is then loaded into the output register in the echo state once the output slot
// is free, and any further echo bytes follow from the same state. Each line
// character is first read from the line memory (registered read) and then loaded
// into the output register.
// The output register keeps a finished response while the receiver stalls;
// the next byte is taken as soon as the editor is idle, even if that response
// is still waiting. A stall stops the echo and line handout sequence in place.
// Reset clears the fill count, the message counter and the output valid. The
// line memory is not cleared: only entries that were written are ever read.
module console_line_editor
	import cle_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [12:8] line_length,
	                                           // [44:13] message_total, then zero pad
	output logic               m_axis_tuser,   // [0] kind: 0 echo, 1 line character
	output logic               m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ECHO,
		ST_LREAD,
		ST_LSEND
	} state_t;

	typedef enum logic [1:0] {
		ECHO_CHAR,
		ECHO_DEL,
		ECHO_CR
	} echo_t;

	state_t              state_q;
	echo_t               echo_q;
	logic [1:0]          step_q;
	logic [BYTE_W-1:0]   rx_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   len_q;
	logic [FILL_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic                out_kind_q;
	logic                out_last_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [CNT_W-1:0]    out_cnt_q;

	// Line memory: one write port, one registered read port.
	logic [CHAR_W-1:0]   line_mem [LINE_SIZE];
	logic [CHAR_W-1:0]   rd_data_q;
	logic                wr_en;
	logic [FILL_W-1:0]   wr_addr;
	logic [CHAR_W-1:0]   wr_data;
	logic                rd_en;

	logic                is_print;
	logic                is_full;
	logic                slot_free;
	logic                out_load;
	logic [BYTE_W-1:0]   echo_byte;
	logic                echo_final;
	logic                line_final;

	assign is_print  = (rx_q >= CH_LOW) && (rx_q <= CH_HIGH);
	assign is_full   = (fill_q >= FILL_W'(LINE_SIZE - 1));
	assign slot_free = !out_valid_q || m_axis_tready;
	// The output register is reloaded in this cycle.
	assign out_load  = ((state_q == ST_ECHO) || (state_q == ST_LSEND)) && slot_free;

	// Stores happen only while decoding; reads happen only during the line
	// handout, which starts after the carriage return is decoded, so a read
	// never overlaps a write to the same entry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = rx_q[CHAR_W-1:0];
		if (state_q == ST_DECODE) begin
			if (is_print && !is_full) begin
				wr_en = 1'b1;
			end else if (rx_q == CH_DEL && fill_q != '0) begin
				wr_en   = 1'b1;
				wr_addr = fill_q - FILL_W'(1);
				wr_data = CH_SPACE[CHAR_W-1:0];
			end
		end
	end

	assign rd_en = (state_q == ST_LREAD);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= line_mem[rd_idx_q];
		end
	end

	// Echo script: one byte for a printable character, DEL SP DEL for a
	// delete, CR LF for a carriage return.
	always_comb begin
		echo_byte  = rx_q;
		echo_final = 1'b1;
		unique case (echo_q)
			ECHO_CHAR: begin
				echo_byte  = rx_q;
				echo_final = 1'b1;
			end
			ECHO_DEL: begin
				echo_byte  = (step_q == 2'd1) ? CH_SPACE : CH_DEL;
				echo_final = (step_q == 2'd2);
			end
			ECHO_CR: begin
				echo_byte  = (step_q == 2'd0) ? CH_CR : CH_LF;
				echo_final = (step_q == 2'd1);
			end
			default: begin
				echo_byte  = rx_q;
				echo_final = 1'b1;
			end
		endcase
	end

	assign line_final = (rd_idx_q == len_q - FILL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			echo_q      <= ECHO_CHAR;
			step_q      <= '0;
			rx_q        <= '0;
			fill_q      <= '0;
			len_q       <= '0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_last_q  <= 1'b0;
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_cnt_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						rx_q    <= s_axis_tdata;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					step_q <= '0;
					if (rx_q == CH_CR) begin
						echo_q  <= ECHO_CR;
						len_q   <= fill_q;
						fill_q  <= '0;
						if (fill_q != '0) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= ST_ECHO;
					end else if (rx_q == CH_DEL && fill_q != '0) begin
						echo_q  <= ECHO_DEL;
						len_q   <= fill_q - FILL_W'(1);
						fill_q  <= fill_q - FILL_W'(1);
						state_q <= ST_ECHO;
					end else if (is_print && !is_full) begin
						echo_q  <= ECHO_CHAR;
						len_q   <= fill_q + FILL_W'(1);
						fill_q  <= fill_q + FILL_W'(1);
						state_q <= ST_ECHO;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ECHO: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b0;
						out_byte_q  <= echo_byte;
						out_len_q   <= LEN_W'(len_q);
						out_cnt_q   <= cnt_q;
						out_last_q  <= echo_final && !(echo_q == ECHO_CR && len_q != '0);
						step_q      <= step_q + 2'd1;
						if (echo_final) begin
							rd_idx_q <= '0;
							state_q  <= (echo_q == ECHO_CR && len_q != '0) ? ST_LREAD : ST_IDLE;
						end
					end
				end
				ST_LREAD: begin
					state_q <= ST_LSEND;
				end
				ST_LSEND: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b1;
						out_byte_q  <= {1'b0, rd_data_q};
						out_len_q   <= LEN_W'(len_q);
						out_cnt_q   <= cnt_q;
						out_last_q  <= line_final;
						if (line_final) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + FILL_W'(1);
							state_q  <= ST_LREAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_len_q, out_byte_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// The line never holds more than LINE_SIZE-1 characters.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_SIZE - 1))
		else $error("fill count beyond line capacity");

	// The message counter only ever steps up by one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("message counter jumped");

	// The line handout only reads entries below the completed line length.
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LREAD || state_q == ST_LSEND) |-> rd_idx_q < len_q)
		else $error("line read beyond completed length");

	// A memory write and a handout read never happen in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("line memory write during handout read");
`endif

endmodule
